/* sv/gaussian_cdf_erf_approx_macros.svh */
// Assertion macros shared by the normal CDF block.
// Included by the top level; depends on nothing else.
`ifndef GAUSSIAN_CDF_ERF_APPROX_MACROS_SVH
`define GAUSSIAN_CDF_ERF_APPROX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCDF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/gcdf_pkg.sv */
// Shared widths, coefficients, register codes and types for the normal CDF block.
// Used by gcdf_div and gaussian_cdf_erf_approx; depends on nothing.
package gcdf_pkg;

   // Sample and configuration widths.
   localparam int SAMPLE_BITS = 16;
   localparam int CFG_W       = 16;
   localparam int X_W         = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
   localparam int DIFF_W      = X_W + 1;
   localparam int MAG_W       = X_W;
   localparam int SCALED_W    = MAG_W + CFG_W;
   localparam int FRAC_SHIFT  = 4;
   localparam int URAW_W      = SCALED_W - FRAC_SHIFT;

   // |t| in Q.16, clamped to 8.0.
   localparam int U_W = 20;
   localparam logic [U_W-1:0] T_LIMIT = 20'd524288;

   // Polynomial coefficients in Q0.16, rounded to nearest.
   localparam int COEF_W = 16;
   localparam logic [COEF_W-1:0] COEF_A1 = 16'd18245;
   localparam logic [COEF_W-1:0] COEF_A2 = 16'd15099;
   localparam logic [COEF_W-1:0] COEF_A3 = 16'd64;
   localparam logic [COEF_W-1:0] COEF_A4 = 16'd5119;

   // Horner intermediate widths, set by the largest value at |t| = 8.0.
   localparam int Q16_SHIFT = 16;
   localparam int P1_W      = 16;
   localparam int P2_W      = 19;
   localparam int P3_W      = 22;
   localparam int D_W       = 25;
   localparam int D2_W      = 33;
   localparam logic [16:0]     ONE_Q16 = 17'd65536;
   localparam logic [D2_W-1:0] D2_MIN  = D2_W'(ONE_Q16);

   // Reciprocal 2^40 / d2, one quotient bit per stage.
   localparam int Q_W            = 25;
   localparam int DIV_STAGES     = Q_W;
   localparam int REM_W          = D2_W;
   localparam int DIVIDEND_SHIFT = 40;
   localparam logic [REM_W-1:0] REM_INIT = REM_W'(1) << (DIVIDEND_SHIFT - Q_W);
   localparam logic [Q_W-1:0]   Q_MAX    = Q_W'(1) << (Q_W - 1);

   // Fourth power and rounding back to Q0.16.
   localparam int SQ_W       = 2 * Q_W;
   localparam int R4_SHIFT   = 32;
   localparam int R4_W       = 17;
   localparam int PROB_EXT_W = 18;
   localparam int PROB_W     = 16;
   localparam logic [SQ_W-1:0]   ROUND_HALF = SQ_W'(1) << (R4_SHIFT - 1);
   localparam logic [PROB_W-1:0] PROB_MAX   = 16'hFFFF;
   localparam logic [PROB_W-1:0] HALF_Q16   = 16'd32768;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEAN  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 1'b1;
   localparam logic [CFG_W-1:0] MEAN_RESET  = 16'd0;
   localparam logic [CFG_W-1:0] SCALE_RESET = 16'd2896;

   // Control that travels with each request down the pipeline.
   typedef struct packed {
      logic valid;
      logic neg;
   } gcdf_tag_type;

endpackage

/* sv/gcdf_div.sv */
// Pipelined restoring divider that forms 2^40 / d2, one quotient bit per stage.
// Depends on gcdf_pkg for widths and the request tag type.
module gcdf_div (
   input  logic                         clock,
   input  logic                         reset,
   input  gcdf_pkg::gcdf_tag_type       in_tag,
   input  logic [gcdf_pkg::D2_W-1:0]    in_divisor,
   output logic                         in_ready,
   output gcdf_pkg::gcdf_tag_type       out_tag,
   output logic [gcdf_pkg::Q_W-1:0]     out_quotient,
   input  logic                         out_ready
);

   // Stage registers; index k holds the state after quotient bit k.
   gcdf_pkg::gcdf_tag_type           tag_ff  [gcdf_pkg::DIV_STAGES];
   logic [gcdf_pkg::REM_W-1:0]       rem_ff  [gcdf_pkg::DIV_STAGES];
   logic [gcdf_pkg::D2_W-1:0]        div_ff  [gcdf_pkg::DIV_STAGES];
   logic [gcdf_pkg::Q_W-1:0]         quot_ff [gcdf_pkg::DIV_STAGES];
   logic [gcdf_pkg::REM_W-1:0]       rem_in  [gcdf_pkg::DIV_STAGES];
   logic [gcdf_pkg::Q_W-1:0]         quot_in [gcdf_pkg::DIV_STAGES];

   // Source of each stage: entry 0 is the input, entry k+1 is stage k.
   gcdf_pkg::gcdf_tag_type           tag_src  [gcdf_pkg::DIV_STAGES+1];
   logic [gcdf_pkg::REM_W-1:0]       rem_src  [gcdf_pkg::DIV_STAGES+1];
   logic [gcdf_pkg::D2_W-1:0]        div_src  [gcdf_pkg::DIV_STAGES+1];
   logic [gcdf_pkg::Q_W-1:0]         quot_src [gcdf_pkg::DIV_STAGES+1];
   logic                             stage_en [gcdf_pkg::DIV_STAGES+1];

   // The leading quotient bits are known to be zero, so the partial
   // remainder starts at the dividend shifted past them.
   assign tag_src[0]  = in_tag;
   assign rem_src[0]  = gcdf_pkg::REM_INIT;
   assign div_src[0]  = in_divisor;
   assign quot_src[0] = '0;
   assign stage_en[gcdf_pkg::DIV_STAGES] = out_ready;

   for (genvar k = 0; k < gcdf_pkg::DIV_STAGES; k++) begin : g_stage
      logic [gcdf_pkg::REM_W:0] trial;
      logic [gcdf_pkg::REM_W:0] remainder_try;

      // One restoring step: shift in a zero and subtract if it fits.
      always_comb begin
         trial         = {rem_src[k], 1'b0};
         remainder_try = trial - {1'b0, div_src[k]};
         if (!remainder_try[gcdf_pkg::REM_W]) begin
            rem_in[k]  = remainder_try[gcdf_pkg::REM_W-1:0];
            quot_in[k] = {quot_src[k][gcdf_pkg::Q_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = trial[gcdf_pkg::REM_W-1:0];
            quot_in[k] = {quot_src[k][gcdf_pkg::Q_W-2:0], 1'b0};
         end
      end

      // A stage loads when it is empty or its contents move on.
      assign stage_en[k] = !tag_ff[k].valid || stage_en[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (stage_en[k]) begin
            tag_ff[k] <= tag_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            rem_ff[k]  <= rem_in[k];
            div_ff[k]  <= div_src[k];
            quot_ff[k] <= quot_in[k];
         end
      end

      assign tag_src[k+1]  = tag_ff[k];
      assign rem_src[k+1]  = rem_ff[k];
      assign div_src[k+1]  = div_ff[k];
      assign quot_src[k+1] = quot_ff[k];
   end

   assign in_ready     = stage_en[0];
   assign out_tag      = tag_src[gcdf_pkg::DIV_STAGES];
   assign out_quotient = quot_src[gcdf_pkg::DIV_STAGES];

endmodule

/* sv/gaussian_cdf_erf_approx.sv */
// Top level of the normal CDF block: centering, scaling, polynomial and output.
// Depends on gcdf_pkg, gcdf_div and gaussian_cdf_erf_approx_macros.svh.
//
// Each request carries one signed Q7.8 sample and yields exactly one unsigned
// Q0.16 probability, in order. The datapath is a 34-stage pipeline: seven
// stages for centering, scaling and the quartic, 25 stages of the restoring
// divider that forms 1/d^2 one quotient bit per stage, one stage for the
// square and one output register. A request can enter in every cycle while the
// output is not stalled, so the sustained rate is one request per clock. Each
// stage holds its request until the next stage has room, so empty stages close
// up behind a stalled output. The user must write mean and scale through the csr
// port only while no request is in flight; the block itself does not enforce it.
`include "gaussian_cdf_erf_approx_macros.svh"

module gaussian_cdf_erf_approx (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [gcdf_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [gcdf_pkg::PROB_W-1:0]             rsp_probability,
   input  logic                                    csr_wr_en,
   input  logic [gcdf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [gcdf_pkg::CFG_W-1:0]              csr_wdata
);

   localparam int PROD1_W = gcdf_pkg::COEF_W + gcdf_pkg::U_W;
   localparam int PROD2_W = gcdf_pkg::P1_W + gcdf_pkg::U_W;
   localparam int PROD3_W = gcdf_pkg::P2_W + gcdf_pkg::U_W;
   localparam int PROD4_W = gcdf_pkg::P3_W + gcdf_pkg::U_W;
   localparam int PROD5_W = 2 * gcdf_pkg::D_W;

   // Configuration registers.
   logic signed [gcdf_pkg::CFG_W-1:0] mean_ff;
   logic [gcdf_pkg::CFG_W-1:0]        scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff  <= gcdf_pkg::MEAN_RESET;
         scale_ff <= gcdf_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gcdf_pkg::CSR_MEAN:  mean_ff  <= csr_wdata;
            gcdf_pkg::CSR_SCALE: scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline registers.
   gcdf_pkg::gcdf_tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff;
   gcdf_pkg::gcdf_tag_type s5_tag_ff, s6_tag_ff, s7_tag_ff, s8_tag_ff, s9_tag_ff;
   gcdf_pkg::gcdf_tag_type s1_tag_in;
   logic [gcdf_pkg::MAG_W-1:0]    s1_mag_ff, s1_mag_in;
   logic [gcdf_pkg::SCALED_W-1:0] s2_scaled_ff, s2_scaled_in;
   logic [gcdf_pkg::U_W-1:0]      s3_u_ff, s3_u_in, s4_u_ff, s5_u_ff;
   logic [gcdf_pkg::P1_W-1:0]     s3_p1_ff, s3_p1_in;
   logic [gcdf_pkg::P2_W-1:0]     s4_p2_ff, s4_p2_in;
   logic [gcdf_pkg::P3_W-1:0]     s5_p3_ff, s5_p3_in;
   logic [gcdf_pkg::D_W-1:0]      s6_d_ff, s6_d_in;
   logic [gcdf_pkg::D2_W-1:0]     s7_d2_ff, s7_d2_in;
   logic [gcdf_pkg::SQ_W-1:0]     s8_sq_ff, s8_sq_in;
   logic [gcdf_pkg::PROB_W-1:0]   s9_prob_ff, s9_prob_in;

   // Stage enables: a stage loads when empty or when its request moves on.
   logic en1, en2, en3, en4, en5, en6, en7, en8, en9;
   logic div_in_ready;
   gcdf_pkg::gcdf_tag_type div_tag;
   logic [gcdf_pkg::Q_W-1:0] div_quotient;

   assign en9 = !s9_tag_ff.valid || !rsp_stall;
   assign en8 = !s8_tag_ff.valid || en9;
   assign en7 = !s7_tag_ff.valid || div_in_ready;
   assign en6 = !s6_tag_ff.valid || en7;
   assign en5 = !s5_tag_ff.valid || en6;
   assign en4 = !s4_tag_ff.valid || en5;
   assign en3 = !s3_tag_ff.valid || en4;
   assign en2 = !s2_tag_ff.valid || en3;
   assign en1 = !s1_tag_ff.valid || en2;
   assign req_stall = !en1;

   // Stage 1: distance from the mean, split into sign and magnitude.
   logic signed [gcdf_pkg::DIFF_W-1:0] x_ext, mean_ext, diff, diff_neg;

   always_comb begin
      x_ext     = gcdf_pkg::DIFF_W'(req_sample);
      mean_ext  = gcdf_pkg::DIFF_W'(mean_ff);
      diff      = x_ext - mean_ext;
      diff_neg  = -diff;
      s1_tag_in = '{valid: req_valid, neg: diff[gcdf_pkg::DIFF_W-1]};
      s1_mag_in = diff[gcdf_pkg::DIFF_W-1] ? diff_neg[gcdf_pkg::MAG_W-1:0]
                                           : diff[gcdf_pkg::MAG_W-1:0];
   end

   // Stage 2: scale the magnitude by 1/(sigma*sqrt2).
   assign s2_scaled_in = gcdf_pkg::SCALED_W'(s1_mag_ff) * gcdf_pkg::SCALED_W'(scale_ff);

   // Stage 3: |t| in Q.16 clamped to 8.0, then the first Horner step.
   logic [gcdf_pkg::URAW_W-1:0] u_raw;
   logic [PROD1_W-1:0]          prod1;

   always_comb begin
      u_raw = s2_scaled_ff[gcdf_pkg::SCALED_W-1:gcdf_pkg::FRAC_SHIFT];
      if (u_raw > gcdf_pkg::URAW_W'(gcdf_pkg::T_LIMIT)) begin
         s3_u_in = gcdf_pkg::T_LIMIT;
      end else begin
         s3_u_in = u_raw[gcdf_pkg::U_W-1:0];
      end
      prod1    = PROD1_W'(gcdf_pkg::COEF_A4) * PROD1_W'(s3_u_in);
      s3_p1_in = gcdf_pkg::P1_W'(gcdf_pkg::COEF_A3)
               + gcdf_pkg::P1_W'(prod1 >> gcdf_pkg::Q16_SHIFT);
   end

   // Stages 4 to 6: remaining Horner steps, one multiply each.
   logic [PROD2_W-1:0] prod2;
   logic [PROD3_W-1:0] prod3;
   logic [PROD4_W-1:0] prod4;

   always_comb begin
      prod2    = PROD2_W'(s3_p1_ff) * PROD2_W'(s3_u_ff);
      s4_p2_in = gcdf_pkg::P2_W'(gcdf_pkg::COEF_A2)
               + gcdf_pkg::P2_W'(prod2 >> gcdf_pkg::Q16_SHIFT);
      prod3    = PROD3_W'(s4_p2_ff) * PROD3_W'(s4_u_ff);
      s5_p3_in = gcdf_pkg::P3_W'(gcdf_pkg::COEF_A1)
               + gcdf_pkg::P3_W'(prod3 >> gcdf_pkg::Q16_SHIFT);
      prod4    = PROD4_W'(s5_p3_ff) * PROD4_W'(s5_u_ff);
      s6_d_in  = gcdf_pkg::D_W'(gcdf_pkg::ONE_Q16)
               + gcdf_pkg::D_W'(prod4 >> gcdf_pkg::Q16_SHIFT);
   end

   // Stage 7: d squared in Q.16.
   logic [PROD5_W-1:0] prod5;

   always_comb begin
      prod5    = PROD5_W'(s6_d_ff) * PROD5_W'(s6_d_ff);
      s7_d2_in = prod5[gcdf_pkg::D2_W+gcdf_pkg::Q16_SHIFT-1:gcdf_pkg::Q16_SHIFT];
   end

   // Control registers of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
         s5_tag_ff <= '0;
         s6_tag_ff <= '0;
         s7_tag_ff <= '0;
      end else begin
         if (en1) s1_tag_ff <= s1_tag_in;
         if (en2) s2_tag_ff <= s1_tag_ff;
         if (en3) s3_tag_ff <= s2_tag_ff;
         if (en4) s4_tag_ff <= s3_tag_ff;
         if (en5) s5_tag_ff <= s4_tag_ff;
         if (en6) s6_tag_ff <= s5_tag_ff;
         if (en7) s7_tag_ff <= s6_tag_ff;
      end
   end

   // Data registers of the front stages.
   always_ff @(posedge clock) begin
      if (en1) s1_mag_ff <= s1_mag_in;
      if (en2) s2_scaled_ff <= s2_scaled_in;
      if (en3) begin
         s3_u_ff  <= s3_u_in;
         s3_p1_ff <= s3_p1_in;
      end
      if (en4) begin
         s4_u_ff  <= s3_u_ff;
         s4_p2_ff <= s4_p2_in;
      end
      if (en5) begin
         s5_u_ff  <= s4_u_ff;
         s5_p3_ff <= s5_p3_in;
      end
      if (en6) s6_d_ff <= s6_d_in;
      if (en7) s7_d2_ff <= s7_d2_in;
   end

   // Reciprocal of d^2 in Q0.24.
   gcdf_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_tag       (s7_tag_ff),
      .in_divisor   (s7_d2_ff),
      .in_ready     (div_in_ready),
      .out_tag      (div_tag),
      .out_quotient (div_quotient),
      .out_ready    (en8)
   );

   // Stage 8: square the reciprocal to get 1/d^4.
   assign s8_sq_in = gcdf_pkg::SQ_W'(div_quotient) * gcdf_pkg::SQ_W'(div_quotient);

   // Stage 9: round to Q0.16 and fold in the sign of t.
   logic [gcdf_pkg::SQ_W-1:0]       sq_round;
   logic [gcdf_pkg::R4_W-1:0]       r4_raw, r4;
   logic [gcdf_pkg::PROB_EXT_W-1:0] prob_ext;

   always_comb begin
      sq_round = s8_sq_ff + gcdf_pkg::ROUND_HALF;
      r4_raw   = gcdf_pkg::R4_W'(sq_round >> gcdf_pkg::R4_SHIFT);
      r4       = (r4_raw > gcdf_pkg::ONE_Q16) ? gcdf_pkg::ONE_Q16 : r4_raw;
      // Negative t gives (1 - erf)/2 = r4/2; otherwise (1 + erf)/2 = (2 - r4)/2.
      if (s8_tag_ff.neg) begin
         prob_ext = gcdf_pkg::PROB_EXT_W'(r4) >> 1;
      end else begin
         prob_ext = ((gcdf_pkg::PROB_EXT_W'(gcdf_pkg::ONE_Q16) << 1)
                    - gcdf_pkg::PROB_EXT_W'(r4)) >> 1;
      end
      if (prob_ext > gcdf_pkg::PROB_EXT_W'(gcdf_pkg::PROB_MAX)) begin
         s9_prob_in = gcdf_pkg::PROB_MAX;
      end else begin
         s9_prob_in = prob_ext[gcdf_pkg::PROB_W-1:0];
      end
   end

   // Back-end control and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s8_tag_ff <= '0;
         s9_tag_ff <= '0;
      end else begin
         if (en8) s8_tag_ff <= div_tag;
         if (en9) s9_tag_ff <= s8_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en8) s8_sq_ff <= s8_sq_in;
      if (en9) s9_prob_ff <= s9_prob_in;
   end

   assign rsp_valid       = s9_tag_ff.valid;
   assign rsp_probability = s9_prob_ff;

   // An empty output register lets a request in through the whole pipeline.
   `GCDF_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, !req_stall, "stall with empty output")
   // The divisor never drops below one, so the quotient fits its width.
   `GCDF_ASSERT_IMPL(a_divisor_floor, clock, reset, s7_tag_ff.valid, s7_d2_ff >= gcdf_pkg::D2_MIN, "d squared below one")
   `GCDF_ASSERT_IMPL(a_quotient_bound, clock, reset, div_tag.valid, div_quotient <= gcdf_pkg::Q_MAX, "reciprocal above one")
   // A sample below the mean never yields more than one half.
   `GCDF_ASSERT_IMPL(a_neg_half, clock, reset, rsp_valid && s9_tag_ff.neg, rsp_probability <= gcdf_pkg::HALF_Q16, "negative side above one half")
   // A request behind a stalled full output stays where it is.
   `GCDF_ASSERT_NEXT(a_stage_holds, clock, reset, s8_tag_ff.valid && rsp_valid && rsp_stall, s8_tag_ff.valid, "request lost behind stall")

endmodule
